// ===== sv/rcu_pkg.sv =====
// Package for the run-control unit: field widths, command, stop-reason and
// error codes, and the request, result and state records.
// No dependencies; imported by rcu_next and run_control_unit.
package rcu_pkg;

  // compared width of instruction indexes and width of the command counter
  localparam int PC_BITS    = 16;
  localparam int SEQ_BITS   = 32;

  // fixed field widths
  localparam int OP_W       = 3;
  localparam int PC_W       = 16;
  localparam int BUDGET_W   = 27;
  localparam int PLEN_W     = 17;
  localparam int CODE_W     = 3;
  localparam int SEQ_OUT_W  = 32;

  // largest step budget a run_until may ask for
  localparam logic [BUDGET_W-1:0] MAX_BUDGET = BUDGET_W'(100000000);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD      = 3'd0,
    OP_RESET     = 3'd1,
    OP_STEP      = 3'd2,
    OP_RUN       = 3'd3,
    OP_RUN_UNTIL = 3'd4,
    OP_PAUSE     = 3'd5,
    OP_OBSERVE   = 3'd6,
    OP_TICK      = 3'd7
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    R_PAUSED  = 3'd0,
    R_RUNNING = 3'd1,
    R_FAULT   = 3'd2,
    R_TARGET  = 3'd3,
    R_LIMIT   = 3'd4
  } reason_t;

  typedef enum logic [CODE_W-1:0] {
    E_NONE   = 3'd0,
    E_BUSY   = 3'd1,
    E_FAULT  = 3'd2,
    E_BAD    = 3'd3,
    E_WINDOW = 3'd4
  } err_t;

  // one request as it sits in the input register
  typedef struct packed {
    op_t                 op;
    logic                step_ok;
    logic                machine_faulted;
    logic [PC_W-1:0]     pc;
    logic [PC_W-1:0]     target_index;
    logic [BUDGET_W-1:0] step_budget;
    logic [PLEN_W-1:0]   program_length;
    logic                window_ok;
  } item_t;

  // one result as it sits in the result register
  typedef struct packed {
    logic                accepted;
    err_t                error_code;
    logic                running;
    reason_t             stop_reason;
    logic                step_taken;
    logic [SEQ_BITS-1:0] sequence_number;
  } result_t;

  // run-control state
  typedef struct packed {
    logic                running;
    logic                targeted;
    reason_t             reason;
    logic [PC_BITS-1:0]  target;
    logic [BUDGET_W-1:0] budget;
    logic [SEQ_BITS-1:0] seq;
  } state_t;

endpackage

// ===== sv/run_control_unit.sv =====
// Top level of the run-control unit: input register, state registers and
// result register around rcu_next; depends on rcu_pkg and rcu_next.
//
// One request per clock cycle, sustained while out_ready is high: a request is
// taken into an input register, its whole state update and result are computed
// in one pass by rcu_next, and the result lands in an output register as the
// request moves on from the input register. The state registers update as the
// request moves into the output register, so every request sees the state left
// by the previous one. Backpressure on out_ready holds the output register and
// then the input register; in_ready stays high while either one can still move.
module run_control_unit
  import rcu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_op,
  input  logic                 in_step_ok,
  input  logic                 in_machine_faulted,
  input  logic [PC_W-1:0]      in_pc,
  input  logic [PC_W-1:0]      in_target_index,
  input  logic [BUDGET_W-1:0]  in_step_budget,
  input  logic [PLEN_W-1:0]    in_program_length,
  input  logic                 in_window_ok,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  output logic [CODE_W-1:0]    out_error_code,
  output logic                 out_running,
  output logic [CODE_W-1:0]    out_stop_reason,
  output logic                 out_step_taken,
  output logic [SEQ_OUT_W-1:0] out_sequence_number
);

  logic    in_vld_r;
  item_t   item_r;
  logic    out_vld_r;
  result_t res_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  logic    adv;

  // a request moves on when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op              <= op_t'(in_op);
      item_r.step_ok         <= in_step_ok;
      item_r.machine_faulted <= in_machine_faulted;
      item_r.pc              <= in_pc;
      item_r.target_index    <= in_target_index;
      item_r.step_budget     <= in_step_budget;
      item_r.program_length  <= in_program_length;
      item_r.window_ok       <= in_window_ok;
    end
  end

  // state update and result
  rcu_next u_next (
    .item_i (item_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.running  <= 1'b0;
      st_r.targeted <= 1'b0;
      st_r.reason   <= R_PAUSED;
      st_r.target   <= '0;
      st_r.budget   <= '0;
      st_r.seq      <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_accepted        = res_r.accepted;
  assign out_error_code      = res_r.error_code;
  assign out_running         = res_r.running;
  assign out_stop_reason     = res_r.stop_reason;
  assign out_step_taken      = res_r.step_taken;
  assign out_sequence_number = SEQ_OUT_W'(res_r.sequence_number);

  // an accepted request never carries an error code
  a_acc_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_error_code == E_NONE)
    else $error("accepted request reports an error code");

  // running flag and running stop reason always go together
  a_run_reason: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.running == (st_r.reason == R_RUNNING))
    else $error("running flag and stop reason disagree");

  // command counter moves by at most one per processed request
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (st_r.seq == $past(st_r.seq)) ||
            (st_r.seq == $past(st_r.seq) + SEQ_BITS'(1)))
    else $error("command counter jumped");

  // state holds while no request moves on
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("state changed without a request");

endmodule

// ===== sv/rcu_next.sv =====
// Next-state and result logic of the run-control unit for one request.
// Purely combinational; depends on rcu_pkg.
module rcu_next
  import rcu_pkg::*;
(
  input  item_t   item_i,
  input  state_t  st_i,
  output state_t  st_o,
  output result_t res_o
);

  logic                pc_hit;
  logic                bad_target;
  logic [BUDGET_W-1:0] budget_dec;
  logic                taken;
  logic                acc;
  err_t                err;

  // target compare in the low PC_BITS bits
  assign pc_hit     = (item_i.pc[PC_BITS-1:0] == st_i.target);
  assign budget_dec = st_i.budget - BUDGET_W'(1);
  assign bad_target = ({1'b0, item_i.target_index} >= item_i.program_length) ||
                      (item_i.step_budget == '0) ||
                      (item_i.step_budget > MAX_BUDGET);

  // command decode and state update
  always_comb begin
    st_o  = st_i;
    taken = 1'b0;
    acc   = 1'b0;
    err   = E_NONE;
    if (item_i.op == OP_TICK) begin
      // background step, only while running
      if (st_i.running) begin
        if (!item_i.step_ok) begin
          st_o.running = 1'b0;
          st_o.reason  = R_FAULT;
        end else begin
          taken = 1'b1;
          if (st_i.targeted) begin
            st_o.budget = budget_dec;
            if (pc_hit) begin
              st_o.running = 1'b0;
              st_o.reason  = R_TARGET;
            end else if (budget_dec == '0) begin
              st_o.running = 1'b0;
              st_o.reason  = R_LIMIT;
            end
          end
        end
      end
    end else begin
      st_o.seq = st_i.seq + SEQ_BITS'(1);
      acc      = 1'b1;
      if (!item_i.window_ok) begin
        acc = 1'b0;
        err = E_WINDOW;
      end else begin
        unique case (item_i.op) inside
          OP_LOAD, OP_RESET: begin
            st_o.running  = 1'b0;
            st_o.targeted = 1'b0;
            st_o.reason   = R_PAUSED;
          end
          OP_STEP: begin
            if (st_i.running) begin
              acc = 1'b0;
              err = E_BUSY;
            end else if (!item_i.step_ok) begin
              acc         = 1'b0;
              err         = E_FAULT;
              st_o.reason = R_FAULT;
            end else begin
              taken       = 1'b1;
              st_o.reason = R_PAUSED;
            end
          end
          OP_RUN: begin
            if (item_i.machine_faulted) begin
              acc = 1'b0;
              err = E_FAULT;
            end else if (!st_i.running) begin
              st_o.running  = 1'b1;
              st_o.targeted = 1'b0;
              st_o.reason   = R_RUNNING;
            end
          end
          OP_RUN_UNTIL: begin
            if (st_i.running) begin
              acc = 1'b0;
              err = E_BUSY;
            end else if (item_i.machine_faulted) begin
              acc = 1'b0;
              err = E_FAULT;
            end else if (bad_target) begin
              acc = 1'b0;
              err = E_BAD;
            end else begin
              st_o.target   = item_i.target_index[PC_BITS-1:0];
              st_o.budget   = item_i.step_budget;
              st_o.targeted = 1'b1;
              if (item_i.pc[PC_BITS-1:0] != item_i.target_index[PC_BITS-1:0]) begin
                st_o.running = 1'b1;
                st_o.reason  = R_RUNNING;
              end else begin
                st_o.running = 1'b0;
                st_o.reason  = R_TARGET;
              end
            end
          end
          OP_PAUSE: begin
            st_o.running  = 1'b0;
            st_o.targeted = 1'b0;
            if (st_i.reason == R_RUNNING) begin
              st_o.reason = R_PAUSED;
            end
          end
          OP_OBSERVE, OP_TICK: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result record
  assign res_o.accepted        = acc;
  assign res_o.error_code      = err;
  assign res_o.running         = st_o.running;
  assign res_o.stop_reason     = st_o.reason;
  assign res_o.step_taken      = taken;
  assign res_o.sequence_number = st_o.seq;

endmodule
